[rtl/core/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

[rtl/core/olte_pkg.sv]
`default_nettype none

package olte_pkg;

  localparam int DATA_W = 32;
  localparam int DEF_CAPACITY = 16;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_DELETE  = 3'd1,
    OP_SORT    = 3'd2,
    OP_REVERSE = 3'd3,
    OP_READ    = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

endpackage

`default_nettype wire

[rtl/core/ordered_list_table_engine.sv]
// one item at a time; busy is high from acceptance until the done beat, except
// for operations answered straight from idle (rejections, unused opcodes, and
// reverse below two entries), which never raise it; all work goes through one
// registered-read entry ram, one access per cycle
// sync reset clears the count and the sequencer; the entry ram is not cleared
// the done beat lasts one cycle and cannot be held off
`default_nettype none

module ordered_list_table_engine
  import olte_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [2:0]               opcode,
  input  wire logic signed [DATA_W-1:0] value,
  input  wire logic [3:0]               position,
  output logic                          done,
  output logic [2:0]                    status,
  output logic [4:0]                    entry_count,
  output logic signed [DATA_W-1:0]      read_value
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = $clog2(CAPACITY);
  localparam int CMPW = (CW > 4) ? CW : 4;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_ADD_HEAD,
    S_DEL_RD,
    S_DEL_CMP,
    S_SH_RD,
    S_SH_WR,
    S_SRT_RDI,
    S_SRT_LDI,
    S_SRT_RDJ,
    S_SRT_CMP,
    S_REV_RDLO,
    S_REV_RDHI,
    S_REV_WRLO,
    S_REV_WRHI,
    S_RD_OUT
  } state_t;

  state_t            state;
  logic [CW-1:0]     occ;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic [DATA_W-1:0] key;
  logic [DATA_W-1:0] cur;

  logic [CW-1:0]     im1;
  logic [CW-1:0]     ip1;
  logic [CMPW-1:0]   pos_w;
  logic [CMPW-1:0]   occ_w;
  logic              gt;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [DATA_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [DATA_W-1:0] rdata;

  assign im1   = i - CW'(1);
  assign ip1   = i + CW'(1);
  assign pos_w = CMPW'(position);
  assign occ_w = CMPW'(occ);
  assign gt    = $signed(cur) > $signed(rdata);

  assign busy        = (state != S_IDLE);
  assign entry_count = 5'(occ);

  olte_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = cur;
    raddr = '0;
    unique case (state)
      S_IDLE: begin
        raddr = pos_w[AW-1:0];
      end
      S_ADD_RD: begin
        raddr = im1[AW-1:0];
      end
      S_ADD_WR: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      S_ADD_HEAD: begin
        we    = 1'b1;
        wdata = key;
      end
      S_DEL_RD: begin
        raddr = i[AW-1:0];
      end
      S_SH_RD: begin
        raddr = ip1[AW-1:0];
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      S_SRT_RDI: begin
        raddr = i[AW-1:0];
      end
      S_SRT_RDJ: begin
        if (j >= occ) begin
          we    = 1'b1;
          waddr = i[AW-1:0];
        end else begin
          raddr = j[AW-1:0];
        end
      end
      S_SRT_CMP: begin
        we    = gt;
        waddr = j[AW-1:0];
      end
      S_REV_RDLO: begin
        raddr = i[AW-1:0];
      end
      S_REV_RDHI: begin
        raddr = j[AW-1:0];
      end
      S_REV_WRLO: begin
        we    = 1'b1;
        waddr = i[AW-1:0];
        wdata = rdata;
      end
      S_REV_WRHI: begin
        we    = 1'b1;
        waddr = j[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      occ   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key <= value;
            case (opcode_t'(opcode))
              OP_ADD: begin
                if (occ == CW'(CAPACITY)) begin
                  done       <= 1'b1;
                  status     <= ST_FULL;
                  read_value <= '0;
                end else begin
                  i     <= occ;
                  state <= S_ADD_RD;
                end
              end
              OP_DELETE: begin
                if (occ == '0) begin
                  done       <= 1'b1;
                  status     <= ST_EMPTY;
                  read_value <= '0;
                end else begin
                  i     <= '0;
                  state <= S_DEL_RD;
                end
              end
              OP_SORT: begin
                i     <= '0;
                state <= S_SRT_RDI;
              end
              OP_REVERSE: begin
                if (occ < CW'(2)) begin
                  done       <= 1'b1;
                  status     <= ST_OK;
                  read_value <= '0;
                end else begin
                  i     <= '0;
                  j     <= occ - CW'(1);
                  state <= S_REV_RDLO;
                end
              end
              OP_READ: begin
                if (pos_w < occ_w) begin
                  state <= S_RD_OUT;
                end else begin
                  done       <= 1'b1;
                  status     <= ST_RANGE;
                  read_value <= '0;
                end
              end
              default: begin
                done       <= 1'b1;
                status     <= ST_OK;
                read_value <= '0;
              end
            endcase
          end
        end
        S_ADD_RD: begin
          state <= (i == '0) ? S_ADD_HEAD : S_ADD_WR;
        end
        S_ADD_WR: begin
          i     <= im1;
          state <= S_ADD_RD;
        end
        S_ADD_HEAD: begin
          occ        <= occ + CW'(1);
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= '0;
          state      <= S_IDLE;
        end
        S_DEL_RD: begin
          if (i >= occ) begin
            done       <= 1'b1;
            status     <= ST_NOT_FOUND;
            read_value <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_DEL_CMP;
          end
        end
        S_DEL_CMP: begin
          if (rdata == key) begin
            state <= S_SH_RD;
          end else begin
            i     <= ip1;
            state <= S_DEL_RD;
          end
        end
        S_SH_RD: begin
          if (ip1 >= occ) begin
            occ        <= occ - CW'(1);
            done       <= 1'b1;
            status     <= ST_OK;
            read_value <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_SH_WR;
          end
        end
        S_SH_WR: begin
          i     <= ip1;
          state <= S_SH_RD;
        end
        S_SRT_RDI: begin
          if (ip1 >= occ) begin
            done       <= 1'b1;
            status     <= ST_OK;
            read_value <= '0;
            state      <= S_IDLE;
          end else begin
            j     <= ip1;
            state <= S_SRT_LDI;
          end
        end
        S_SRT_LDI: begin
          cur   <= rdata;
          state <= S_SRT_RDJ;
        end
        S_SRT_RDJ: begin
          if (j >= occ) begin
            i     <= ip1;
            state <= S_SRT_RDI;
          end else begin
            state <= S_SRT_CMP;
          end
        end
        S_SRT_CMP: begin
          if (gt) begin
            cur <= rdata;
          end
          j     <= j + CW'(1);
          state <= S_SRT_RDJ;
        end
        S_REV_RDLO: begin
          if (i >= j) begin
            done       <= 1'b1;
            status     <= ST_OK;
            read_value <= '0;
            state      <= S_IDLE;
          end else begin
            state <= S_REV_RDHI;
          end
        end
        S_REV_RDHI: begin
          cur   <= rdata;
          state <= S_REV_WRLO;
        end
        S_REV_WRLO: begin
          state <= S_REV_WRHI;
        end
        S_REV_WRHI: begin
          i     <= ip1;
          j     <= j - CW'(1);
          state <= S_REV_RDLO;
        end
        S_RD_OUT: begin
          done       <= 1'b1;
          status     <= ST_OK;
          read_value <= rdata;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/olte_ram.sv]
`default_nettype none

module olte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/olte_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module olte_checker
  import olte_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     start,
  input wire logic                     busy,
  input wire logic                     done,
  input wire logic [2:0]               status,
  input wire logic signed [DATA_W-1:0] read_value
);

  // a result beat only ever shows up with the engine free again
  `CHK_IMPLIES(a_done_idle, clk, rst, done, !busy)

  // an accepted command either keeps the engine busy or answers at once
  `CHK_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done)

  // no beat without a command in flight
  `CHK_NEXT(a_no_spurious, clk, rst, !busy && !start, !done)

  // read data only comes with a good status
  `CHK_IMPLIES(a_read_ok, clk, rst, done && (read_value != '0), status == ST_OK)

endmodule

bind ordered_list_table_engine olte_checker u_olte_checker (.*);

`default_nettype wire

[verif/ordered_list_table_engine_tb.sv]
`timescale 1ns / 1ps

typedef struct {
  olte_pkg::status_t  st;
  logic [4:0]         cnt;
  logic signed [31:0] rd;
} list_result_t;

class list_tracker;
  logic signed [31:0] held [olte_pkg::DEF_CAPACITY];
  int                 held_count;
  list_result_t       expected_q [$];
  int                 mismatches;

  function new();
    held_count = 0;
    mismatches = 0;
  endfunction

  function void note_item(logic [2:0] op, logic signed [31:0] v, logic [3:0] pos);
    list_result_t       r;
    int                 i;
    int                 j;
    int                 hit;
    logic signed [31:0] t;
    r.st = olte_pkg::ST_OK;
    r.rd = '0;
    case (op)
      olte_pkg::OP_ADD: begin
        if (held_count >= olte_pkg::DEF_CAPACITY) begin
          r.st = olte_pkg::ST_FULL;
        end else begin
          for (i = held_count; i > 0; i--) held[i] = held[i-1];
          held[0] = v;
          held_count++;
        end
      end
      olte_pkg::OP_DELETE: begin
        if (held_count == 0) begin
          r.st = olte_pkg::ST_EMPTY;
        end else begin
          hit = -1;
          for (i = 0; i < held_count; i++)
            if (hit < 0 && held[i] == v) hit = i;
          if (hit < 0) begin
            r.st = olte_pkg::ST_NOT_FOUND;
          end else begin
            for (i = hit; i + 1 < held_count; i++) held[i] = held[i+1];
            held_count--;
          end
        end
      end
      olte_pkg::OP_SORT: begin
        for (i = 1; i < held_count; i++) begin
          t = held[i];
          j = i - 1;
          while (j >= 0 && held[j] > t) begin
            held[j+1] = held[j];
            j--;
          end
          held[j+1] = t;
        end
      end
      olte_pkg::OP_REVERSE: begin
        for (i = 0; i < held_count / 2; i++) begin
          t = held[i];
          held[i] = held[held_count-1-i];
          held[held_count-1-i] = t;
        end
      end
      olte_pkg::OP_READ: begin
        if (int'(pos) < held_count) r.rd = held[pos];
        else r.st = olte_pkg::ST_RANGE;
      end
      default: ;
    endcase
    r.cnt = held_count[4:0];
    expected_q.push_back(r);
  endfunction

  function void check_done(logic [2:0] st, logic [4:0] cnt, logic signed [31:0] rd);
    list_result_t e;
    if (expected_q.size() == 0) begin
      $error("done beat with nothing pending: status %0d entry_count %0d read_value %0d",
             st, cnt, rd);
      mismatches++;
      return;
    end
    e = expected_q.pop_front();
    if (st !== e.st) begin
      $error("status: expected %0d, actual %0d", e.st, st);
      mismatches++;
    end
    if (cnt !== e.cnt) begin
      $error("entry_count: expected %0d, actual %0d", e.cnt, cnt);
      mismatches++;
    end
    if (rd !== e.rd) begin
      $error("read_value: expected %0d, actual %0d", e.rd, rd);
      mismatches++;
    end
  endfunction
endclass

module ordered_list_table_engine_tb;
  import olte_pkg::*;

  localparam int          CLK_HALF        = 6;
  localparam int          RANDOM_ITEMS    = 800;
  localparam int          DRAIN_CYCLES    = 300;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam logic [2:0]  OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  OP_UNUSED_LAST  = 3'd7;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic [3:0]         position;
  logic               done;
  logic [2:0]         status;
  logic [4:0]         entry_count;
  logic signed [31:0] read_value;

  list_tracker tracker;
  int          cycle_count;

  ordered_list_table_engine u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .opcode      (opcode),
    .value       (value),
    .position    (position),
    .done        (done),
    .status      (status),
    .entry_count (entry_count),
    .read_value  (read_value)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) tracker.check_done(status, entry_count, read_value);
  end

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] v,
                           input logic [3:0] pos);
    @(negedge clk);
    start    = 1'b1;
    opcode   = op;
    value    = v;
    position = pos;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_item(op, v, pos);
  endtask

  task automatic hold_off(input int n);
    if (n > 0) begin
      @(negedge clk);
      start    = 1'b0;
      opcode   = 3'($urandom);
      value    = $urandom;
      position = 4'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $signed(32'($urandom_range(0, 6))) - 32'sd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 45 : 10)) return OP_ADD;
    if (r < 55) return OP_DELETE;
    if (r < 63) return OP_SORT;
    if (r < 71) return OP_REVERSE;
    if (r < 95) return OP_READ;
    return 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
  endfunction

  task automatic run_random();
    int                 sent;
    int                 burst;
    int                 target;
    logic [2:0]         op;
    logic signed [31:0] v;
    logic [3:0]         pos;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: target = 0;
        1: target = DEF_CAPACITY;
        default: target = $urandom_range(0, DEF_CAPACITY);
      endcase
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      repeat (burst) begin
        op  = pick_op(tracker.held_count < target);
        v   = pick_value();
        pos = 4'($urandom_range(0, 15));
        if (op == OP_DELETE && tracker.held_count > 0 && $urandom_range(0, 9) < 7)
          v = tracker.held[$urandom_range(0, tracker.held_count - 1)];
        if (op == OP_READ && tracker.held_count > 0 && $urandom_range(0, 1) == 0)
          pos = 4'($urandom_range(0, tracker.held_count - 1));
        send_item(op, v, pos);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 10));
    end
  endtask

  initial begin
    tracker  = new();
    rst      = 1'b1;
    start    = 1'b0;
    opcode   = '0;
    value    = '0;
    position = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corner cases: empty list, single entry, extreme values, out-of-range reads, unused opcodes
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_DELETE, 32'sd5, 4'd0);
    send_item(OP_SORT, 32'sd0, 4'd0);
    send_item(OP_REVERSE, 32'sd0, 4'd0);
    send_item(OP_ADD, 32'sd7, 4'd0);
    send_item(OP_SORT, 32'sd0, 4'd0);
    send_item(OP_REVERSE, 32'sd0, 4'd0);
    send_item(OP_ADD, 32'sh7fffffff, 4'd0);
    send_item(OP_ADD, 32'sh80000000, 4'd0);
    send_item(OP_ADD, -32'sd3, 4'd0);
    send_item(OP_ADD, -32'sd2, 4'd0);
    send_item(OP_ADD, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd15);
    send_item(OP_READ, 32'sd0, 4'd6);
    send_item(OP_READ, 32'sd0, 4'd5);
    send_item(OP_REVERSE, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_SORT, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd0);
    send_item(OP_READ, 32'sd0, 4'd5);
    send_item(OP_DELETE, -32'sd2, 4'd0);
    send_item(OP_DELETE, 32'sd12345, 4'd0);
    send_item(OP_UNUSED_FIRST, 32'shffffffff, 4'd15);
    send_item(OP_UNUSED_LAST, 32'shffffffff, 4'd15);

    run_random();

    @(negedge clk);
    start = 1'b0;
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/olte_pkg.sv
rtl/core/olte_ram.sv
rtl/core/ordered_list_table_engine.sv
rtl/core/olte_checker.sv
verif/ordered_list_table_engine_tb.sv
